[hw/rtl/sfs_pkg.sv]
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

    localparam int MAX_FRAMES = 256;
    localparam int FRAME_LIM  = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

    localparam int ACC_W  = 56;
    localparam int DEN_W  = 24;
    localparam int MOD_W  = 9;
    localparam int QUO_W  = 8;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] MAG_BITS = STEP_W'(ACC_W);
    localparam logic [STEP_W-1:0] IDX_BITS = STEP_W'(QUO_W);

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [2:0] {
        CMD_QUERY  = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_RESUME = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_FRAME_TICKS = 3'd0,
        REG_FRAME_COUNT = 3'd1,
        REG_GRID_COLS   = 3'd2,
        REG_GRID_ROWS   = 3'd3,
        REG_MODE_FLAGS  = 3'd4,
        REG_ORIGIN_XY   = 3'd5,
        REG_STEP_XY     = 3'd6,
        REG_RATE_SCALE  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
        logic [MOD_W-1:0]  modulus;
        logic [STEP_W-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUO_W-1:0]  quot;
        logic [DEN_W-1:0]  rem;
    } t_div_rsp;

endpackage

[hw/rtl/sfs_divider.sv]
// Bit-serial restoring divider that keeps the quotient reduced modulo a small count.
module sfs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfs_pkg::t_div_req i_req,
    output sfs_pkg::t_div_rsp o_rsp
);
    import sfs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [ACC_W-1:0]  r_dvd;
    logic [DEN_W-1:0]  r_den;
    logic [MOD_W-1:0]  r_mod;
    logic [DEN_W-1:0]  r_rem;
    logic [QUO_W-1:0]  r_q;

    logic [DEN_W:0]    w_trial;
    logic              w_ge;
    logic [DEN_W:0]    w_diff;
    logic [DEN_W-1:0]  n_rem;
    logic [MOD_W-1:0]  w_qt;
    logic [MOD_W-1:0]  w_qdiff;
    logic [QUO_W-1:0]  n_q;

    assign w_trial = {r_rem, r_dvd[ACC_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    assign w_qt    = {r_q, w_ge};
    assign w_qdiff = w_qt - r_mod;
    assign n_q     = (w_qt >= r_mod) ? w_qdiff[QUO_W-1:0] : w_qt[QUO_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= i_req.nbits;
                r_dvd  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_mod  <= i_req.modulus;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_q    <= n_q;
                r_dvd  <= {r_dvd[ACC_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == STEP_W'(1));
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

[hw/rtl/sprite_frame_sequencer_core.sv]
// Sprite frame sequencer top level: play-time accumulator, frame selection and sheet position.
// A start, stop, pause or resume transaction is taken in the idle state and gives no result.
// A query, once accepted, scales and accumulates the elapsed time, loads the shared
// bit-serial divider to find the frame number modulo the frame count, takes the frame and
// reloads the divider to split the frame into a grid cell, then hands off, picks the cell
// and loads the output. The divider works out one quotient bit per cycle. The input is
// not ready while a query is being worked on, so a new query is taken only after the last
// one has loaded its result, which waits while the previous result is still held; a
// finished result waits in the output register while the next transaction is taken.
module sprite_frame_sequencer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command [2:0], time_now [34:3]
    input  logic [sfs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // frame_index [7:0], cell_col [15:8], cell_row [23:16], pixel_x [47:24], pixel_y [72:48]
    output logic [sfs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [2:0]                           i_cfg_index,
    input  logic [31:0]                          i_cfg_data
);
    import sfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_GO1, S_WAIT1, S_FRAME, S_GO2, S_WAIT2, S_PIX, S_OUT
    } t_state;

    logic [15:0] r_frame_ticks;
    logic [8:0]  r_frame_count;
    logic [8:0]  r_grid_cols;
    logic [8:0]  r_grid_rows;
    logic [1:0]  r_mode_flags;
    logic [31:0] r_origin_xy;
    logic [31:0] r_step_xy;
    logic [15:0] r_rate_scale;

    t_state             r_state;
    logic signed [ACC_W-1:0] r_acc;
    logic [31:0]        r_last_time;
    logic [31:0]        r_pause_time;
    logic               r_running;
    logic               r_paused;
    logic [31:0]        r_now;
    logic signed [48:0] r_prod;
    logic [MOD_W-1:0]   r_n;
    logic               r_neg;
    logic [QUO_W-1:0]   r_frame;
    logic [QUO_W-1:0]   r_col;
    logic [QUO_W-1:0]   r_row;
    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_div_req w_req;
    t_div_rsp w_rsp;

    t_cmd               w_cmd;
    logic [31:0]        w_time;
    logic               w_in_acc;
    logic               w_active;
    logic [31:0]        w_delta;
    logic signed [48:0] w_prod;
    logic signed [ACC_W:0] w_sum;
    logic [ACC_W-1:0]   w_sat;
    logic [8:0]         w_gc;
    logic [8:0]         w_gr;
    logic [17:0]        w_cells;
    logic [17:0]        w_cnt_raw;
    logic [MOD_W-1:0]   w_n;
    logic [15:0]        w_ticks;
    logic [ACC_W-1:0]   w_mag;
    logic [MOD_W-1:0]   w_r;
    logic [MOD_W-1:0]   w_f0;
    logic [MOD_W-1:0]   w_f1;
    logic [8:0]         w_grid_div;
    logic [23:0]        w_px;
    logic [24:0]        w_py;
    logic               w_out_free;

    assign w_cmd    = t_cmd'(s_axis_tdata[2:0]);
    assign w_time   = s_axis_tdata[34:3];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ticks <= 16'd1;
            r_frame_count <= 9'd1;
            r_grid_cols   <= 9'd1;
            r_grid_rows   <= 9'd1;
            r_mode_flags  <= 2'd0;
            r_origin_xy   <= 32'd0;
            r_step_xy     <= 32'd0;
            r_rate_scale  <= 16'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FRAME_TICKS: r_frame_ticks <= i_cfg_data[15:0];
                REG_FRAME_COUNT: r_frame_count <= i_cfg_data[8:0];
                REG_GRID_COLS:   r_grid_cols   <= i_cfg_data[8:0];
                REG_GRID_ROWS:   r_grid_rows   <= i_cfg_data[8:0];
                REG_MODE_FLAGS:  r_mode_flags  <= i_cfg_data[1:0];
                REG_ORIGIN_XY:   r_origin_xy   <= i_cfg_data;
                REG_STEP_XY:     r_step_xy     <= i_cfg_data;
                REG_RATE_SCALE:  r_rate_scale  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_active = r_running && !r_paused;
    assign w_delta  = r_now - r_last_time;
    assign w_prod   = $signed({1'b0, w_delta}) * $signed(r_rate_scale);
    assign w_sum    = $signed({r_acc[ACC_W-1], r_acc}) + $signed({{8{r_prod[48]}}, r_prod});
    always_comb begin
        case (w_sum[ACC_W:ACC_W-1])
            2'b01:   w_sat = {1'b0, {(ACC_W-1){1'b1}}};
            2'b10:   w_sat = {1'b1, {(ACC_W-1){1'b0}}};
            default: w_sat = w_sum[ACC_W-1:0];
        endcase
    end

    assign w_gc      = (r_grid_cols == 9'd0) ? 9'd1 : r_grid_cols;
    assign w_gr      = (r_grid_rows == 9'd0) ? 9'd1 : r_grid_rows;
    assign w_cells   = w_gc * w_gr;
    assign w_cnt_raw = (r_frame_count == 9'd0) ? w_cells : {9'd0, r_frame_count};
    assign w_n       = (w_cnt_raw > 18'(FRAME_LIM)) ? MOD_W'(FRAME_LIM) : w_cnt_raw[MOD_W-1:0];

    assign w_ticks = (r_frame_ticks == 16'd0) ? 16'd1 : r_frame_ticks;
    assign w_mag   = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;

    assign w_r  = {1'b0, w_rsp.quot};
    assign w_f0 = r_neg ? (r_n - 1'b1 - w_r) : w_r;
    assign w_f1 = r_mode_flags[1] ? (r_n - 1'b1 - w_f0) : w_f0;

    assign w_grid_div = r_mode_flags[0] ? w_gr : w_gc;

    always_comb begin
        w_req = '0;
        if (r_state == S_GO1) begin
            w_req.start    = 1'b1;
            w_req.dividend = w_mag;
            w_req.divisor  = {w_ticks, 8'd0};
            w_req.modulus  = r_n;
            w_req.nbits    = MAG_BITS;
        end else if (r_state == S_GO2) begin
            w_req.start    = 1'b1;
            w_req.dividend = {r_frame, {(ACC_W-QUO_W){1'b0}}};
            w_req.divisor  = DEN_W'(w_grid_div);
            w_req.modulus  = MOD_W'(256);
            w_req.nbits    = IDX_BITS;
        end
    end

    sfs_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_px = 24'(r_origin_xy[15:0]) + 24'(r_col) * 24'(r_step_xy[15:0]);
    assign w_py = 25'(r_row) * 25'(r_step_xy[31:16]) - 25'(r_origin_xy[31:16]);
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_acc        <= '0;
            r_last_time  <= '0;
            r_pause_time <= '0;
            r_running    <= 1'b0;
            r_paused     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_n          <= MOD_W'(1);
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_now <= w_time;
                        case (w_cmd)
                            CMD_QUERY: r_state <= S_MUL;
                            CMD_START: begin
                                r_acc       <= '0;
                                r_last_time <= w_time;
                                r_running   <= 1'b1;
                                r_paused    <= 1'b0;
                            end
                            CMD_STOP: begin
                                r_running <= 1'b0;
                                r_paused  <= 1'b0;
                            end
                            CMD_PAUSE: begin
                                if (r_running && !r_paused) begin
                                    r_paused     <= 1'b1;
                                    r_pause_time <= w_time;
                                end
                            end
                            CMD_RESUME: begin
                                if (r_running && r_paused) begin
                                    r_last_time <= r_last_time + (w_time - r_pause_time);
                                end
                                r_paused <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod <= w_active ? w_prod : '0;
                    if (w_active) begin
                        r_last_time <= r_now;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= w_sat;
                    r_n     <= w_n;
                    r_state <= S_GO1;
                end
                S_GO1: begin
                    r_neg   <= r_acc[ACC_W-1];
                    r_state <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (w_rsp.done) begin
                        r_state <= S_FRAME;
                    end
                end
                S_FRAME: begin
                    r_frame <= w_f1[QUO_W-1:0];
                    r_state <= S_GO2;
                end
                S_GO2: r_state <= S_WAIT2;
                S_WAIT2: begin
                    if (w_rsp.done) begin
                        r_state <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (r_mode_flags[0]) begin
                        r_col <= w_rsp.quot;
                        r_row <= w_rsp.rem[QUO_W-1:0];
                    end else begin
                        r_col <= w_rsp.rem[QUO_W-1:0];
                        r_row <= w_rsp.quot;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {7'd0, w_py, w_px, r_row, r_col, r_frame};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("divider started while busy");

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_rsp.busy)
        else $error("input ready while divider runs");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_n != '0) && (r_n <= MOD_W'(FRAME_LIM)))
        else $error("effective frame count out of range");

    a_frame_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (MOD_W'(r_frame) < r_n))
        else $error("frame index not below frame count");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> $past(w_rsp.busy))
        else $error("divider done without a run");

endmodule

[tb/sfs_checker.sv]
// Channel monitor, frame prediction and result comparison for the sprite frame sequencer.
module sfs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sfs_pkg::IN_TDATA_W-1:0]    i_cmd_data,
    input  logic                              i_cmd_valid,
    input  logic                              i_cmd_ready,
    input  logic [sfs_pkg::OUT_TDATA_W-1:0]   i_spot_data,
    input  logic                              i_spot_valid,
    input  logic                              i_spot_ready,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [2:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    output int                                o_fail_count,
    output int                                o_due_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfs_pkg::*;

    localparam longint ACC_HI = 64'sh007F_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef struct packed {
        logic [24:0] pixel_y;
        logic [23:0] pixel_x;
        logic [7:0]  cell_row;
        logic [7:0]  cell_col;
        logic [7:0]  frame;
    } t_frame_spot;

    t_frame_spot spots_due [$];

    logic [15:0]        ticks_r;
    logic [8:0]         count_r;
    logic [8:0]         cols_r;
    logic [8:0]         rows_r;
    logic [1:0]         mode_r;
    logic [31:0]        origin_r;
    logic [31:0]        step_r;
    logic signed [15:0] rate_r;

    longint      play_acc;
    logic [31:0] last_t;
    logic [31:0] pause_t;
    bit          running;
    bit          paused;

    task automatic clear_player();
        ticks_r  = 16'd1;
        count_r  = 9'd1;
        cols_r   = 9'd1;
        rows_r   = 9'd1;
        mode_r   = 2'd0;
        origin_r = 32'd0;
        step_r   = 32'd0;
        rate_r   = 16'sd256;
        play_acc = 0;
        last_t   = 32'd0;
        pause_t  = 32'd0;
        running  = 1'b0;
        paused   = 1'b0;
        spots_due.delete();
    endtask

    // Update the play state for one command; a query queues the frame it selects.
    task automatic advance_player(input logic [2:0] code, input logic [31:0] stamp);
        logic [31:0]       dt;
        longint            sum;
        longint unsigned   mag;
        longint unsigned   den;
        int unsigned       gc;
        int unsigned       gr;
        int unsigned       n;
        int unsigned       r;
        int unsigned       f;
        int unsigned       col;
        int unsigned       row;
        longint            py;
        t_frame_spot       spot;
        case (code)
            CMD_START: begin
                play_acc = 0;
                last_t   = stamp;
                running  = 1'b1;
                paused   = 1'b0;
            end
            CMD_STOP: begin
                running = 1'b0;
                paused  = 1'b0;
            end
            CMD_PAUSE: begin
                if (running && !paused) begin
                    paused  = 1'b1;
                    pause_t = stamp;
                end
            end
            CMD_RESUME: begin
                if (running && paused) last_t = last_t + (stamp - pause_t);
                paused = 1'b0;
            end
            CMD_QUERY: begin
                if (running && !paused) begin
                    dt  = stamp - last_t;
                    sum = play_acc + longint'({32'd0, dt}) * longint'(rate_r);
                    if (sum > ACC_HI) sum = ACC_HI;
                    else if (sum < ACC_LO) sum = ACC_LO;
                    play_acc = sum;
                    last_t   = stamp;
                end
                gc = (cols_r == 9'd0) ? 1 : cols_r;
                gr = (rows_r == 9'd0) ? 1 : rows_r;
                n  = (count_r == 9'd0) ? gc * gr : count_r;
                if (n > FRAME_LIM) n = FRAME_LIM;
                if (n < 1) n = 1;
                den = longint'((ticks_r == 16'd0) ? 1 : ticks_r) << 8;
                mag = (play_acc < 0) ? longint'(-play_acc) : play_acc;
                r   = int'((mag / den) % longint'(n));
                f   = (play_acc < 0) ? n - 1 - r : r;
                if (mode_r[1]) f = n - 1 - f;
                if (mode_r[0]) begin
                    col = f / gr;
                    row = f % gr;
                end else begin
                    col = f % gc;
                    row = f / gc;
                end
                py = longint'(row) * longint'(step_r[31:16]) - longint'(origin_r[31:16]);
                spot.frame    = 8'(f);
                spot.cell_col = 8'(col);
                spot.cell_row = 8'(row);
                spot.pixel_x  = 24'(longint'(origin_r[15:0])
                                    + longint'(col) * longint'(step_r[15:0]));
                spot.pixel_y  = 25'(py);
                spots_due.push_back(spot);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_spot seen;
        t_frame_spot want;
        if (!i_rst_n) begin
            clear_player();
        end else begin
            if (i_spot_valid && i_spot_ready) begin
                seen = i_spot_data[$bits(t_frame_spot)-1:0];
                if (spots_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result with none due: idx %0d col %0d row %0d x %0d y %0d",
                                 $realtime, seen.frame, seen.cell_col, seen.cell_row,
                                 seen.pixel_x, $signed(seen.pixel_y));
                    o_fail_count++;
                end else begin
                    want = spots_due.pop_front();
                    if (seen.frame != want.frame || seen.cell_col != want.cell_col ||
                        seen.cell_row != want.cell_row || seen.pixel_x != want.pixel_x ||
                        seen.pixel_y != want.pixel_y) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: expected idx %0d col %0d row %0d x %0d y %0d",
                                     $realtime, want.frame, want.cell_col, want.cell_row,
                                     want.pixel_x, $signed(want.pixel_y));
                            $display("%0t: actual   idx %0d col %0d row %0d x %0d y %0d",
                                     $realtime, seen.frame, seen.cell_col, seen.cell_row,
                                     seen.pixel_x, $signed(seen.pixel_y));
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FRAME_TICKS: ticks_r  = i_cfg_data[15:0];
                    REG_FRAME_COUNT: count_r  = i_cfg_data[8:0];
                    REG_GRID_COLS:   cols_r   = i_cfg_data[8:0];
                    REG_GRID_ROWS:   rows_r   = i_cfg_data[8:0];
                    REG_MODE_FLAGS:  mode_r   = i_cfg_data[1:0];
                    REG_ORIGIN_XY:   origin_r = i_cfg_data;
                    REG_STEP_XY:     step_r   = i_cfg_data;
                    REG_RATE_SCALE:  rate_r   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd_valid && i_cmd_ready)
                advance_player(i_cmd_data[2:0], i_cmd_data[34:3]);
        end
        o_due_count = spots_due.size();
    end

endmodule

[tb/tb.sv]
// Testbench top for the sprite frame sequencer: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sfs_pkg::*;

    localparam int          SETTLE_CYCLES = 90;
    localparam int          RANDOM_ITEMS  = 1200;
    localparam int          SAT_QUERIES   = 275;
    localparam logic [2:0]  CMD_UNDEF_LO  = 3'(int'(CMD_RESUME) + 1);

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [2:0]             i_cfg_index;
    logic [31:0]            i_cfg_data;

    int          fail_count;
    int          due_count;
    bit          src_idle;
    bit          snk_idle;
    logic [31:0] setting [8];
    logic [31:0] clock_now;
    int          played;

    sprite_frame_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sfs_checker frame_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_data   (s_axis_tdata),
        .i_cmd_valid  (s_axis_tvalid),
        .i_cmd_ready  (s_axis_tready),
        .i_spot_data  (m_axis_tdata),
        .i_spot_valid (m_axis_tvalid),
        .i_spot_ready (m_axis_tready),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_due_count  (due_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: stall a random number of cycles once a result is waiting.
    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = snk_idle ? $urandom_range(0, 11) : 0;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                do @(posedge i_clk); while (!m_axis_tvalid);
                @(negedge i_clk);
                repeat (gap - 1) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    task automatic send_item(input logic [2:0] code, input logic [31:0] stamp);
        int gap;
        gap = src_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - 35){1'b0}}, stamp, code};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_count != 0) @(negedge i_clk);
    endtask

    task automatic load_setting();
        int i;
        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        for (i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= setting[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          k;
        int          phase;
        int          len;
        int          span;
        logic [31:0] junk;
        logic [31:0] stamp;
        logic [2:0]  code;

        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = 3'd0;
        i_cfg_data    = 32'd0;
        src_idle      = 1'b1;
        snk_idle      = 1'b1;
        clock_now     = 32'd0;
        played        = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, zero frame time, zero count and grid, timer wrap,
        // pause and resume in every state, undefined codes, backward and negative time.
        send_item(CMD_QUERY, 32'd100);
        setting[REG_FRAME_TICKS] = 32'd0;
        setting[REG_FRAME_COUNT] = 32'd0;
        setting[REG_GRID_COLS]   = 32'd4;
        setting[REG_GRID_ROWS]   = 32'd0;
        setting[REG_MODE_FLAGS]  = 32'd0;
        setting[REG_ORIGIN_XY]   = 32'hFFFF_FFFF;
        setting[REG_STEP_XY]     = 32'hFFFF_FFFF;
        setting[REG_RATE_SCALE]  = 32'd256;
        load_setting();
        send_item(CMD_START,  32'hFFFF_FFF0);
        send_item(CMD_QUERY,  32'hFFFF_FFF5);
        send_item(CMD_QUERY,  32'd3);
        send_item(CMD_PAUSE,  32'd10);
        send_item(CMD_QUERY,  32'd50);
        send_item(CMD_RESUME, 32'd60);
        send_item(CMD_QUERY,  32'd70);
        send_item(CMD_PAUSE,  32'd71);
        send_item(CMD_PAUSE,  32'd72);
        send_item(CMD_RESUME, 32'd80);
        send_item(CMD_RESUME, 32'd81);
        send_item(CMD_QUERY,  32'd85);
        send_item(CMD_STOP,   32'd90);
        send_item(CMD_QUERY,  32'd100);
        send_item(CMD_PAUSE,  32'd105);
        send_item(CMD_RESUME, 32'd110);
        send_item(CMD_QUERY,  32'd120);
        for (k = 0; k < 3; k++) send_item(CMD_UNDEF_LO + 3'(k), $urandom);
        send_item(CMD_QUERY,  32'd130);

        setting[REG_FRAME_TICKS] = 32'd1;
        setting[REG_FRAME_COUNT] = 32'd511;
        setting[REG_GRID_COLS]   = 32'd511;
        setting[REG_GRID_ROWS]   = 32'd256;
        setting[REG_MODE_FLAGS]  = 32'd3;
        setting[REG_ORIGIN_XY]   = 32'h8000_00FF;
        setting[REG_STEP_XY]     = 32'h0101_0003;
        setting[REG_RATE_SCALE]  = 32'hFFFF_FF00;
        load_setting();
        send_item(CMD_START, 32'd0);
        send_item(CMD_QUERY, 32'd1);
        send_item(CMD_QUERY, 32'd1000);
        send_item(CMD_QUERY, 32'hFFFF_FFFF);

        // Random phases; the first two drive the accumulator into both saturation limits.
        phase = 0;
        while (played < RANDOM_ITEMS) begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            junk     = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;

            k = $urandom_range(0, 9);
            setting[REG_FRAME_TICKS] = {junk[31:16], (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF :
                                        (k == 2) ? 16'd1 : 16'($urandom_range(1, 40))};
            k = $urandom_range(0, 9);
            setting[REG_FRAME_COUNT] = {junk[31:9], (k == 0) ? 9'd0 : (k == 1) ? 9'd256 :
                                        (k == 2) ? 9'd511 : (k == 3) ? 9'd1 :
                                        9'($urandom_range(1, 24))};
            k = $urandom_range(0, 9);
            setting[REG_GRID_COLS] = {junk[31:9], (k == 0) ? 9'd0 : (k == 1) ? 9'd1 :
                                      (k == 2) ? 9'd256 : (k == 3) ? 9'd511 :
                                      9'($urandom_range(1, 8))};
            k = $urandom_range(0, 9);
            setting[REG_GRID_ROWS] = {junk[31:9], (k == 0) ? 9'd0 : (k == 1) ? 9'd1 :
                                      (k == 2) ? 9'd256 : (k == 3) ? 9'd511 :
                                      9'($urandom_range(1, 8))};
            setting[REG_MODE_FLAGS] = {junk[31:2], 2'($urandom_range(0, 3))};
            k = $urandom_range(0, 5);
            setting[REG_ORIGIN_XY] = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
            k = $urandom_range(0, 5);
            setting[REG_STEP_XY]   = (k == 0) ? 32'd0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
            k = $urandom_range(0, 9);
            setting[REG_RATE_SCALE] = {junk[31:16], (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 :
                                       (k == 2) ? 16'h0000 : (k == 3) ? 16'h0100 :
                                       16'($urandom_range(0, 2048) - 1024)};
            if (phase < 2)
                setting[REG_RATE_SCALE] = (phase == 0) ? 32'h0000_7FFF : 32'h0000_8000;
            load_setting();

            send_item(CMD_START, clock_now);
            played++;
            if (phase < 2) begin
                // Step back a little each time: the unsigned delta is then close to full scale.
                for (k = 0; k < SAT_QUERIES; k++) begin
                    clock_now = clock_now - 32'($urandom_range(1, 16));
                    send_item(CMD_QUERY, clock_now);
                    played++;
                end
            end else begin
                len  = $urandom_range(15, 60);
                span = $urandom_range(1, 400);
                repeat (len) begin
                    k = $urandom_range(0, 99);
                    clock_now = clock_now + (($urandom_range(0, 19) == 0) ?
                                             $urandom : 32'($urandom_range(0, span)));
                    stamp = clock_now;
                    if (k < 60)      code = CMD_QUERY;
                    else if (k < 68) code = CMD_PAUSE;
                    else if (k < 76) code = CMD_RESUME;
                    else if (k < 80) code = CMD_STOP;
                    else if (k < 85) code = CMD_START;
                    else             code = CMD_UNDEF_LO + 3'($urandom_range(0, 2));
                    if (k >= 92) begin
                        code  = 3'($urandom_range(0, 7));
                        stamp = $urandom;
                    end
                    send_item(code, stamp);
                    if (code <= CMD_RESUME) played++;
                    if ($urandom_range(0, 29) == 0) drain();
                end
            end
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_divider.sv
hw/rtl/sprite_frame_sequencer_core.sv
tb/sfs_checker.sv
tb/tb.sv
